@@ src/modbus_rtu_read_holding_slave_unit_defines.svh @@
// ============================================================================
// Assertion macros for the Modbus RTU read-holding slave
// Shared property wrappers used at the end of the top level.
// ============================================================================
`ifndef MODBUS_RTU_READ_HOLDING_SLAVE_UNIT_DEFINES_SVH
`define MODBUS_RTU_READ_HOLDING_SLAVE_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define MRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define MRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/mrs_pkg.sv @@
// ============================================================================
// mrs_pkg
// Types, constants and the CRC helper for the Modbus RTU slave.
// ============================================================================
package mrs_pkg;

  localparam int RegCountDef = 8;
  localparam int FrameMaxDef = 256;

  localparam logic [1:0] OpByte    = 2'd0;
  localparam logic [1:0] OpSilence = 2'd1;
  localparam logic [1:0] OpWrite   = 2'd2;
  localparam logic [1:0] OpSpare   = 2'd3;

  // outgoing byte source
  localparam logic [1:0] SelBody  = 2'd0;
  localparam logic [1:0] SelCrcLo = 2'd1;
  localparam logic [1:0] SelCrcHi = 2'd2;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [7:0]  FuncRead = 8'h03;
  localparam logic [7:0]  ExcFlag  = 8'h80;
  localparam logic [7:0]  ExcFunc  = 8'h01;
  localparam logic [7:0]  ExcData  = 8'h02;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_END,
    ST_SEND,
    ST_CRC_LO,
    ST_CRC_HI
  } mrs_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic take_byte;
    logic take_write;
    logic clear;
    logic start_tx;
    logic advance;
  } mrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic frame_full;
    logic frame_empty;
    logic frame_ok;
    logic body_done;
  } mrs_stat_t;

  // one byte through the reflected CRC-16
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/modbus_rtu_read_holding_slave_unit.sv @@
// ============================================================================
// modbus_rtu_read_holding_slave_unit
// Modbus RTU slave answering function 0x03 with local holding registers.
// ============================================================================
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  op, rx_byte, reg_index, reg_value
// out       output     out_valid/out_stall tx_byte, last
// cfg       input      cfg_valid/cfg_ready slave_address
//
// A write is taken on acceptance; a byte is accepted, then its length is checked,
// and a byte that fills the frame also ends it. Silence is accepted, then ends
// the frame; a reply then sends the body bytes (3 to 19), closes the body and
// sends the two CRC bytes, the sequencer reading one register per data byte pair.
// Reset clears the frame, CRC, registers and sets the address to 1.
// Input is stalled while a response is in progress; output stalls hold it.
module modbus_rtu_read_holding_slave_unit
  import mrs_pkg::*;
#(
  parameter int RegCount = RegCountDef,
  parameter int FrameMax = FrameMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [2:0]  reg_index_i,
  input  logic [15:0] reg_value_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  slave_address_i
);

`include "modbus_rtu_read_holding_slave_unit_defines.svh"

  mrs_cmd_t   cmd;
  mrs_stat_t  stat;
  logic [1:0] sel;
  logic [7:0] body_byte, crc_lo, crc_hi;
  logic [7:0] addr_q;

  assign cfg_ready = 1'b1;

  // hold the station address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                       addr_q <= 8'd1;
    else if (cfg_valid && cfg_ready)   addr_q <= slave_address_i;
  end

  mrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_sel_o   (sel)
  );

  mrs_datapath #(.RegCount(RegCount), .FrameMax(FrameMax)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .slave_address_i (addr_q),
    .rx_byte_i       (rx_byte_i),
    .reg_index_i     (reg_index_i),
    .reg_value_i     (reg_value_i),
    .body_byte_o     (body_byte),
    .crc_lo_o        (crc_lo),
    .crc_hi_o        (crc_hi)
  );

  // pick the outgoing byte
  always_comb begin
    case (sel)
      SelCrcLo: tx_byte_o = crc_lo;
      SelCrcHi: tx_byte_o = crc_hi;
      default:  tx_byte_o = body_byte;
    endcase
  end
  assign last_o = (sel == SelCrcHi);

  `MRS_ASSERT_IMP(a_no_accept_while_out, clk_i, rst_ni, out_valid, in_stall)
  `MRS_ASSERT_IMP(a_last_from_crc, clk_i, rst_ni, out_valid && last_o, sel == SelCrcHi)
  `MRS_ASSERT_NEXT(a_last_then_idle, clk_i, rst_ni,
    out_valid && last_o && !out_stall, !out_valid)

endmodule

@@ src/mrs_datapath.sv @@
// ============================================================================
// mrs_datapath
// Frame capture, receive CRC, holding registers and response byte builder.
// ============================================================================
module mrs_datapath
  import mrs_pkg::*;
#(
  parameter int RegCount = RegCountDef,
  parameter int FrameMax = FrameMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mrs_cmd_t    cmd_i,
  output mrs_stat_t   stat_o,
  input  logic [7:0]  slave_address_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [2:0]  reg_index_i,
  input  logic [15:0] reg_value_i,
  output logic [7:0]  body_byte_o,
  output logic [7:0]  crc_lo_o,
  output logic [7:0]  crc_hi_o
);

  localparam int LenW = $clog2(FrameMax + 1);
  localparam int RegW = (RegCount > 1) ? $clog2(RegCount) : 1;

  logic [15:0]     rx_crc_q, rx_crc_d;
  logic [7:0]      dly0_q, dly1_q;
  logic [7:0]      hdr_q [6];
  logic [LenW-1:0] len_q;
  logic [15:0]     regs_q [RegCount];

  logic [15:0]     tx_crc_q;
  logic [5:0]      tx_pos_q;
  logic [5:0]      tx_len_q;
  logic [7:0]      tx_b1_q, tx_b2_q;
  logic [RegW-1:0] rd_idx_q;

  // header decode
  logic [15:0] start_w, count_w;
  logic [16:0] span_w;
  logic        addr_ok, crc_ok, is_read, range_bad;

  assign start_w   = {hdr_q[2], hdr_q[3]};
  assign count_w   = {hdr_q[4], hdr_q[5]};
  assign span_w    = {1'b0, start_w} + {1'b0, count_w};
  assign addr_ok   = (hdr_q[0] == slave_address_i);
  assign crc_ok    = ({dly0_q, dly1_q} == rx_crc_q);
  assign is_read   = (hdr_q[1] == FuncRead);
  assign range_bad = (count_w == 16'd0) || (span_w > 17'(RegCount));

  assign stat_o.frame_empty = (len_q == '0);
  assign stat_o.frame_full  = (len_q == LenW'(FrameMax));
  assign stat_o.frame_ok    = (len_q >= LenW'(8)) && addr_ok && crc_ok;
  assign stat_o.body_done   = (tx_pos_q == tx_len_q);

  assign rx_crc_d = crc_feed(rx_crc_q, dly1_q);

  // receive side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_crc_q <= CrcInit;
      dly0_q   <= '0;
      dly1_q   <= '0;
      len_q    <= '0;
    end else if (cmd_i.clear) begin
      rx_crc_q <= CrcInit;
      dly0_q   <= '0;
      dly1_q   <= '0;
      len_q    <= '0;
    end else if (cmd_i.take_byte) begin
      if (len_q >= LenW'(2)) begin
        rx_crc_q <= rx_crc_d;
      end
      dly1_q <= dly0_q;
      dly0_q <= rx_byte_i;
      len_q  <= len_q + LenW'(1);
    end
  end

  // capture the first six bytes
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && (len_q < LenW'(6))) begin
      hdr_q[len_q[2:0]] <= rx_byte_i;
    end
  end

  // holding registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) regs_q[i] <= '0;
    end else if (cmd_i.take_write && (32'(reg_index_i) < RegCount)) begin
      regs_q[RegW'(reg_index_i)] <= reg_value_i;
    end
  end

  // response byte at the current position
  always_comb begin
    logic [15:0] v;
    v = regs_q[rd_idx_q];
    case (tx_pos_q)
      6'd0:    body_byte_o = slave_address_i;
      6'd1:    body_byte_o = tx_b1_q;
      6'd2:    body_byte_o = tx_b2_q;
      default: body_byte_o = tx_pos_q[0] ? v[15:8] : v[7:0];
    endcase
  end

  assign crc_lo_o = tx_crc_q[7:0];
  assign crc_hi_o = tx_crc_q[15:8];

  // transmit sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_pos_q <= '0;
      tx_len_q <= '0;
      tx_crc_q <= CrcInit;
      tx_b1_q  <= '0;
      tx_b2_q  <= '0;
      rd_idx_q <= '0;
    end else if (cmd_i.start_tx) begin
      tx_pos_q <= '0;
      tx_crc_q <= CrcInit;
      rd_idx_q <= start_w[RegW-1:0];
      if (!is_read) begin
        tx_b1_q  <= hdr_q[1] | ExcFlag;
        tx_b2_q  <= ExcFunc;
        tx_len_q <= 6'd3;
      end else if (range_bad) begin
        tx_b1_q  <= FuncRead | ExcFlag;
        tx_b2_q  <= ExcData;
        tx_len_q <= 6'd3;
      end else begin
        tx_b1_q  <= FuncRead;
        tx_b2_q  <= {count_w[6:0], 1'b0};
        tx_len_q <= 6'(3 + 2 * count_w[5:0]);
      end
    end else if (cmd_i.advance) begin
      tx_crc_q <= crc_feed(tx_crc_q, body_byte_o);
      tx_pos_q <= tx_pos_q + 6'd1;
      if (tx_pos_q >= 6'd3 && !tx_pos_q[0]) begin
        rd_idx_q <= rd_idx_q + RegW'(1);
      end
    end
  end

endmodule

@@ src/mrs_ctrl.sv @@
// ============================================================================
// mrs_ctrl
// Controller: routes operations, runs frame check and response send.
// ============================================================================
module mrs_ctrl
  import mrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  mrs_stat_t  stat_i,
  output mrs_cmd_t   cmd_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_sel_o
);

  mrs_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    out_sel_o   = SelBody;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (op_i)
            OpByte: begin
              cmd_o.take_byte = 1'b1;
              state_d = ST_CHECK;
            end
            OpSilence: if (!stat_i.frame_empty) state_d = ST_END;
            OpWrite:   cmd_o.take_write = 1'b1;
            default:   ;
          endcase
        end
      end
      ST_CHECK: begin
        // a byte that fills the frame ends it at once
        if (stat_i.frame_full) state_d = ST_END;
        else                   state_d = ST_IDLE;
      end
      ST_END: begin
        cmd_o.clear = 1'b1;
        if (stat_i.frame_ok) begin
          cmd_o.start_tx = 1'b1;
          state_d = ST_SEND;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.advance = 1'b1;
        end
        if (stat_i.body_done) begin
          out_valid_o   = 1'b0;
          cmd_o.advance = 1'b0;
          state_d       = ST_CRC_LO;
        end
      end
      ST_CRC_LO: begin
        out_valid_o = 1'b1;
        out_sel_o   = SelCrcLo;
        if (!out_stall_i) state_d = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        out_valid_o = 1'b1;
        out_sel_o   = SelCrcHi;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ test/tb_modbus_rtu_read_holding_slave_unit.sv @@
// ----------------------------------------------------------------------------
// Testbench for the Modbus RTU read-holding slave
// Feeds line bytes, silence events and local register writes, predicts every
// response byte with an internal slave model and checks the output stream.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_read_holding_slave_unit;
  import mrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRegs = RegCountDef;
  localparam int MaxFrame = FrameMaxDef;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } resp_byte_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
  } line_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op_i;
  logic [7:0]  rx_byte_i;
  logic [2:0]  reg_index_i;
  logic [15:0] reg_value_i;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  slave_address_i;

  modbus_rtu_read_holding_slave_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op_i           (op_i),
    .rx_byte_i      (rx_byte_i),
    .reg_index_i    (reg_index_i),
    .reg_value_i    (reg_value_i),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .slave_address_i(slave_address_i)
  );

  // predictor state
  logic [7:0]  own_addr;
  logic [15:0] rx_crc;
  logic [7:0]  tail_new, tail_old;
  logic [7:0]  hdr [6];
  int          rx_len;
  logic [15:0] regs [NumRegs];

  resp_byte_t  pending_tx[$];
  bit          failed;
  bit          rx_done;
  int          rx_count;

  // directed table: item plus typed expectation
  line_item_t  dir_items[$];
  resp_byte_t  dir_resp[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c ^= {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  // queue a response body followed by its CRC
  task automatic queue_reply(input logic [7:0] body[$]);
    logic [15:0] c;
    c = CrcInit;
    foreach (body[i]) begin
      c = crc_step(c, body[i]);
      pending_tx.push_back('{body[i], 1'b0});
    end
    pending_tx.push_back('{c[7:0], 1'b0});
    pending_tx.push_back('{c[15:8], 1'b1});
  endtask

  task automatic close_frame();
    logic [7:0]  body[$];
    logic [15:0] first, cnt;
    if (rx_len >= 8 && hdr[0] == own_addr && {tail_new, tail_old} == rx_crc) begin
      body.push_back(own_addr);
      if (hdr[1] == FuncRead) begin
        first = {hdr[2], hdr[3]};
        cnt = {hdr[4], hdr[5]};
        if (cnt == 0 || 32'(first) + 32'(cnt) > NumRegs) begin
          body.push_back(FuncRead | ExcFlag);
          body.push_back(ExcData);
        end else begin
          body.push_back(FuncRead);
          body.push_back(8'(cnt * 2));
          for (int i = 0; i < cnt; i++) begin
            body.push_back(regs[first + i][15:8]);
            body.push_back(regs[first + i][7:0]);
          end
        end
      end else begin
        body.push_back(hdr[1] | ExcFlag);
        body.push_back(ExcFunc);
      end
      queue_reply(body);
    end
    rx_crc = CrcInit;
    tail_new = '0;
    tail_old = '0;
    rx_len = 0;
  endtask

  task automatic predict_slave(input line_item_t it);
    case (it.op)
      OpByte: begin
        if (rx_len >= 2) rx_crc = crc_step(rx_crc, tail_old);
        tail_old = tail_new;
        tail_new = it.rx_byte;
        if (rx_len < 6) hdr[rx_len] = it.rx_byte;
        rx_len++;
        if (rx_len >= MaxFrame) close_frame();
      end
      OpSilence: if (rx_len != 0) close_frame();
      OpWrite: if (it.reg_index < NumRegs) regs[it.reg_index] = it.reg_value;
      default: ;
    endcase
  endtask

  // short gap, occasionally long
  function automatic int idle_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // drive one transaction; valid drops at the next negedge when a gap or drain follows
  task automatic send_line_item(input line_item_t it);
    int gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    op_i <= it.op;
    rx_byte_i <= it.rx_byte;
    reg_index_i <= it.reg_index;
    reg_value_i <= it.reg_value;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_slave(it);
  endtask

  task automatic send_bytes(input logic [7:0] b[$]);
    foreach (b[i]) send_line_item('{OpByte, b[i], 3'd0, 16'd0});
  endtask

  // frame with its CRC appended, one bit flipped when corrupt is set
  task automatic send_frame(input logic [7:0] b[$], input bit corrupt);
    logic [15:0] c;
    c = CrcInit;
    foreach (b[i]) c = crc_step(c, b[i]);
    if (corrupt) c ^= 16'(1 << $urandom_range(0, 15));
    b.push_back(c[7:0]);
    b.push_back(c[15:8]);
    send_bytes(b);
    send_line_item('{OpSilence, 8'd0, 3'd0, 16'd0});
  endtask

  task automatic drain_wait();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_tx.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] a);
    drain_wait();
    cfg_valid <= 1'b1;
    slave_address_i <= a;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    own_addr = a;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // check response bytes against the predicted stream
  always @(posedge clk_i) begin
    resp_byte_t exp_b;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_tx.size() == 0) begin
        $error("unexpected response byte tx_byte=%h last=%b", tx_byte_o, last_o);
        failed = 1'b1;
      end else begin
        exp_b = pending_tx.pop_front();
        if (tx_byte_o !== exp_b.tx_byte) begin
          $error("tx_byte expected %h actual %h", exp_b.tx_byte, tx_byte_o);
          failed = 1'b1;
        end
        if (last_o !== exp_b.last) begin
          $error("last expected %b actual %b", exp_b.last, last_o);
          failed = 1'b1;
        end
        rx_count++;
      end
    end
  end

  // random receiver stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_done || $urandom_range(0, 3) != 0) out_stall <= 1'b0;
      else begin
        out_stall <= 1'b1;
        repeat (idle_len() + 1) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // random read request, mostly in range
  task automatic random_request();
    logic [7:0] b[$];
    logic [15:0] first, cnt;
    int pick;
    pick = $urandom_range(0, 9);
    first = 16'($urandom_range(0, NumRegs - 1));
    cnt = 16'($urandom_range(1, NumRegs - first));
    if (pick == 0) cnt = 0;
    if (pick == 1) first = 16'($urandom);
    if (pick == 2) cnt = 16'($urandom);
    b.push_back($urandom_range(0, 5) == 0 ? 8'($urandom) : own_addr);
    b.push_back($urandom_range(0, 6) == 0 ? 8'($urandom) : FuncRead);
    b.push_back(first[15:8]);
    b.push_back(first[7:0]);
    b.push_back(cnt[15:8]);
    b.push_back(cnt[7:0]);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) b.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      b = b[0:$urandom_range(0, 4)];
      send_bytes(b);
      send_line_item('{OpSilence, 8'd0, 3'd0, 16'd0});
    end else begin
      send_frame(b, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    line_item_t it;
    logic [7:0] b[$];
    int items;
    in_valid = 1'b0;
    op_i = OpByte;
    rx_byte_i = '0;
    reg_index_i = '0;
    reg_value_i = '0;
    cfg_valid = 1'b0;
    slave_address_i = 8'd1;
    failed = 1'b0;
    rx_done = 1'b0;
    rx_count = 0;
    own_addr = 8'd1;
    rx_crc = CrcInit;
    tail_new = '0;
    tail_old = '0;
    rx_len = 0;
    foreach (hdr[i]) hdr[i] = '0;
    foreach (regs[i]) regs[i] = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: register writes at extremes, ignored op value
    dir_items.push_back('{OpWrite, 8'h00, 3'd0, 16'hFFFF});
    dir_items.push_back('{OpWrite, 8'h00, 3'd7, 16'h0000});
    dir_items.push_back('{OpWrite, 8'hFF, 3'd3, 16'hA55A});
    dir_items.push_back('{OpSpare, 8'hFF, 3'd7, 16'hFFFF});
    dir_items.push_back('{OpSilence, 8'h00, 3'd0, 16'h0});
    // well-formed read of register 0 after reset address 1
    dir_items.push_back('{OpByte, 8'h01, 3'd0, 16'h0});
    dir_items.push_back('{OpByte, 8'h03, 3'd0, 16'h0});
    dir_items.push_back('{OpByte, 8'h00, 3'd0, 16'h0});
    dir_items.push_back('{OpByte, 8'h00, 3'd0, 16'h0});
    dir_items.push_back('{OpByte, 8'h00, 3'd0, 16'h0});
    dir_items.push_back('{OpByte, 8'h01, 3'd0, 16'h0});
    dir_items.push_back('{OpByte, 8'h84, 3'd0, 16'h0});
    dir_items.push_back('{OpByte, 8'h0A, 3'd0, 16'h0});
    dir_items.push_back('{OpSilence, 8'h00, 3'd0, 16'h0});
    // short frame, no reply
    dir_items.push_back('{OpByte, 8'h01, 3'd0, 16'h0});
    dir_items.push_back('{OpByte, 8'h03, 3'd0, 16'h0});
    dir_items.push_back('{OpSilence, 8'h00, 3'd0, 16'h0});
    // reply to the read: 01 03 02 FF FF + CRC, typed in where obvious
    dir_resp.push_back('{8'h01, 1'b0});
    dir_resp.push_back('{8'h03, 1'b0});
    dir_resp.push_back('{8'h02, 1'b0});
    dir_resp.push_back('{8'hFF, 1'b0});
    dir_resp.push_back('{8'hFF, 1'b0});
    foreach (dir_items[i]) begin
      send_line_item(dir_items[i]);
      if (dir_items[i].op == OpSilence && i == 13) begin
        // compare the typed header bytes with the predicted stream
        for (int k = 0; k < dir_resp.size() && k < pending_tx.size(); k++)
          if (pending_tx[k] != dir_resp[k]) begin
            $error("tx_byte expected %h actual %h", dir_resp[k].tx_byte,
                   pending_tx[k].tx_byte);
            failed = 1'b1;
          end
      end
    end

    // exception replies, a full-span read, no-reply frames and a frame with a tail
    send_frame('{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
    send_frame('{8'h01, 8'h03, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
    send_frame('{8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0);
    send_frame('{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h08}, 1'b0);
    send_frame('{8'h01, 8'h03, 8'h00, 8'h07, 8'h00, 8'h02}, 1'b0);
    send_frame('{8'h02, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0);
    send_frame('{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
    send_frame('{8'h01, 8'h03, 8'h00, 8'h01, 8'h00, 8'h02, 8'h55}, 1'b0);

    // hold the sender until every reply is out
    drain_wait();

    // maximum-length frame ends without silence
    b.delete();
    b.push_back(8'h01);
    b.push_back(8'h03);
    repeat (MaxFrame - 4) b.push_back(8'($urandom));
    begin
      logic [15:0] c;
      c = CrcInit;
      foreach (b[i]) c = crc_step(c, b[i]);
      b.push_back(c[7:0]);
      b.push_back(c[15:8]);
    end
    send_bytes(b);

    // random phases over several addresses, extremes included
    items = 0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_address(8'd247);
        1: write_address(8'd1);
        default: write_address(8'($urandom_range(1, 247)));
      endcase
      for (int n = 0; n < 2; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          it.op = $urandom_range(0, 5) == 0 ? OpSpare : OpWrite;
          it.rx_byte = 8'($urandom);
          it.reg_index = 3'($urandom);
          it.reg_value = 16'($urandom);
          send_line_item(it);
        end else if ($urandom_range(0, 9) == 0) begin
          send_line_item('{OpByte, 8'($urandom), 3'($urandom), 16'($urandom)});
          send_line_item('{OpSilence, 8'($urandom), 3'($urandom), 16'($urandom)});
        end else begin
          random_request();
        end
        items++;
      end
    end

    drain_wait();
    rx_done = 1'b1;
    repeat (20) @(negedge clk_i);
    if (!failed && pending_tx.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/mrs_pkg.sv
src/mrs_datapath.sv
src/mrs_ctrl.sv
src/modbus_rtu_read_holding_slave_unit.sv
test/tb_modbus_rtu_read_holding_slave_unit.sv
